FILE: hdl/xcs_pkg.sv
package xcs_pkg;

	localparam int PadLength = 127;
	localparam int DigestBytes = 32;

	localparam logic MODE_SEAL = 1'b0;
	localparam logic MODE_OPEN = 1'b1;

	localparam logic [31:0] INIT_WORDS [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_TABLE [128] = '{
		8'hA0, 8'h92, 8'hD1, 8'h06, 8'h07, 8'hDB, 8'h32, 8'hA1,
		8'hAE, 8'h01, 8'hF5, 8'hC5, 8'h1E, 8'h84, 8'h4F, 8'hE3,
		8'h53, 8'hCA, 8'h37, 8'hF4, 8'hA7, 8'hB0, 8'h4D, 8'hA0,
		8'h18, 8'hB7, 8'hC2, 8'h97, 8'hDA, 8'h5F, 8'h53, 8'h2B,
		8'h75, 8'hFA, 8'h48, 8'h16, 8'hF8, 8'hD4, 8'h8A, 8'h6F,
		8'h61, 8'h05, 8'hF4, 8'hE2, 8'hFD, 8'h04, 8'hB5, 8'hA3,
		8'h0F, 8'hFC, 8'h44, 8'h92, 8'hCB, 8'h32, 8'hE6, 8'h1B,
		8'hB9, 8'hB1, 8'h2E, 8'h01, 8'hB0, 8'h56, 8'h53, 8'h36,
		8'hD2, 8'hD1, 8'h50, 8'h3D, 8'hDE, 8'h5B, 8'h2E, 8'h0E,
		8'h52, 8'hFD, 8'hDF, 8'h2F, 8'h7B, 8'hCA, 8'h63, 8'h50,
		8'hA4, 8'h67, 8'h5D, 8'h23, 8'h17, 8'hC0, 8'h52, 8'hE1,
		8'hA6, 8'h30, 8'h7C, 8'h2B, 8'hB6, 8'h70, 8'h36, 8'h5B,
		8'h2A, 8'h27, 8'h69, 8'h33, 8'hF5, 8'h63, 8'h7B, 8'h36,
		8'h3F, 8'h26, 8'h9B, 8'hA3, 8'hED, 8'h7A, 8'h53, 8'h00,
		8'hA4, 8'h48, 8'hB3, 8'h50, 8'h9E, 8'h14, 8'hA0, 8'h52,
		8'hDE, 8'h7E, 8'h10, 8'h2B, 8'h1B, 8'h77, 8'h6E, 8'h00
	};

	localparam logic [7:0] SALT_INTRO [64] = '{
		8'h9E, 8'hC9, 8'h9C, 8'hD7, 8'h0E, 8'hD3, 8'h3C, 8'h44,
		8'hFB, 8'h93, 8'h03, 8'hDC, 8'hEB, 8'h39, 8'hB4, 8'h2A,
		8'h19, 8'h47, 8'hE9, 8'h63, 8'h4B, 8'hA2, 8'h33, 8'h44,
		8'h16, 8'hBF, 8'h82, 8'hA2, 8'hBA, 8'h63, 8'h55, 8'hB6,
		8'h3D, 8'h9D, 8'hF2, 8'h4B, 8'h5F, 8'h7B, 8'h6A, 8'hB2,
		8'h62, 8'h1D, 8'hC2, 8'h1B, 8'h68, 8'hE5, 8'hC8, 8'hB5,
		8'h3A, 8'h05, 8'h90, 8'h00, 8'hE8, 8'hA8, 8'h10, 8'h3D,
		8'hE2, 8'hEC, 8'hF0, 8'h0C, 8'hB2, 8'hED, 8'h4F, 8'h6D
	};

	localparam logic [7:0] SALT_OUTRO [64] = '{
		8'hD6, 8'hC0, 8'h1C, 8'h59, 8'h8B, 8'hC8, 8'hB8, 8'hCB,
		8'h46, 8'hE1, 8'h53, 8'hFC, 8'h82, 8'h8C, 8'h75, 8'h75,
		8'h13, 8'hE0, 8'h45, 8'hDF, 8'h32, 8'h69, 8'h3C, 8'h75,
		8'hF0, 8'h59, 8'hF8, 8'hD9, 8'hA2, 8'h5F, 8'hB2, 8'h17,
		8'hE0, 8'h80, 8'h52, 8'hDB, 8'hEA, 8'h89, 8'h73, 8'h99,
		8'h75, 8'h79, 8'hAF, 8'hCB, 8'h2E, 8'h80, 8'h07, 8'hE6,
		8'hF1, 8'h26, 8'hE0, 8'h03, 8'h0A, 8'hE6, 8'h6F, 8'hF6,
		8'h41, 8'hBF, 8'h7E, 8'h59, 8'hC2, 8'hAE, 8'h55, 8'hFD
	};

	// handshake between byte sequencer and compression engine
	typedef struct packed {
		logic start;
	} xcs_cmp_req_t;

	typedef struct packed {
		logic busy;
	} xcs_cmp_sts_t;

endpackage

FILE: hdl/xorpad_cipher_with_salted_sha256.sv
// Channel | Handshake             | Fields
// in      | in_valid / in_ready   | in_byte, is_last
// out     | out_valid / out_ready | out_byte, is_digest, end_of_run
// cfg     | mode_we               | mode_wdata
// Open mode: one item per cycle while the result register drains.
// Seal mode: each byte is taken, then absorbed; each full 64-byte block adds a
// compression (start, byte loads, 64 rounds, fold) with input held off.
// The first byte of a message adds 64 intro writes; the last adds 64 outro writes,
// padding and length writes, two or three compressions and 32 digest items.
// Reset clears control and loads the initial hash words. A stalled result register
// holds input and digest output.
module xorpad_cipher_with_salted_sha256
	import xcs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       mode_we,
	input  logic       mode_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       is_digest,
	output logic       end_of_run
);

	typedef enum logic [2:0] {
		S_IDLE, S_INTRO, S_DATA, S_OUTRO, S_PAD, S_LEN, S_FLUSH, S_DIG
	} state_t;

	state_t       state_q;
	logic         mode_q;
	logic [6:0]   pos_q;
	logic         phase_q;
	logic [63:0]  bits_q;
	logic [6:0]   k_q;
	logic [5:0]   pidx_q;
	logic [7:0]   c_q;
	logic         last_q;
	logic         pad_pend_q;
	xcs_cmp_req_t req;
	xcs_cmp_sts_t sts;
	logic         blk_we;
	logic [5:0]   blk_waddr;
	logic [7:0]   blk_wdata;
	logic         init_hash;
	logic [31:0]  hash_rdata;
	logic [7:0]   dig_byte;
	logic         out_free;
	logic         accept;
	logic [7:0]   cipher_w;
	logic [7:0]   len_byte;
	logic [6:0]   pos_next;
	logic         out_load;
	logic [7:0]   out_load_byte;
	logic         out_load_dig;
	logic         out_load_eor;

	xcs_compress u_cmp (
		.clk, .arst_n, .req, .sts,
		.blk_we, .blk_waddr, .blk_wdata,
		.init_hash, .hash_raddr(k_q[4:2]), .hash_rdata
	);

	always_comb begin
		unique case (k_q[1:0])
			2'd0: dig_byte = hash_rdata[31:24];
			2'd1: dig_byte = hash_rdata[23:16];
			2'd2: dig_byte = hash_rdata[15:8];
			default: dig_byte = hash_rdata[7:0];
		endcase
	end

	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free && !sts.busy && !mode_we;
	assign accept = in_valid && in_ready;
	assign cipher_w = in_byte ^ PAD_TABLE[pos_q];
	assign pos_next = (pos_q == 7'(PadLength - 1)) ? '0 : 7'(pos_q + 7'd1);
	assign len_byte = 8'(bits_q >> {3'(3'd7 - k_q[2:0]), 3'b000});

	// block writer: one byte per free cycle, length bytes go to the block tail
	always_comb begin
		blk_we = 1'b0;
		blk_waddr = bits_q[8:3];
		blk_wdata = 8'h00;
		unique case (state_q)
			S_INTRO: begin
				blk_we = !sts.busy;
				blk_wdata = SALT_INTRO[k_q[5:0]];
			end
			S_DATA: begin
				blk_we = !sts.busy;
				blk_wdata = c_q;
			end
			S_OUTRO: begin
				blk_we = !sts.busy;
				blk_wdata = SALT_OUTRO[k_q[5:0]];
			end
			S_PAD: begin
				blk_we = !sts.busy;
				blk_waddr = pidx_q;
				blk_wdata = pad_pend_q ? 8'h80 : 8'h00;
			end
			S_LEN: begin
				blk_we = !sts.busy;
				blk_waddr = {3'b111, k_q[2:0]};
				blk_wdata = len_byte;
			end
			default: ;
		endcase
	end

	// result register load: cipher byte on intake, digest bytes at the end
	assign out_load_dig = (state_q == S_DIG);
	assign out_load = accept || (out_load_dig && out_free && !mode_we);
	assign out_load_byte = out_load_dig ? dig_byte : cipher_w;
	assign out_load_eor = out_load_dig ? (k_q == 7'(DigestBytes - 1))
		: (mode_q == MODE_OPEN || !is_last);

	// result register: load a new item or drop the accepted one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			out_byte <= '0;
			is_digest <= 1'b0;
			end_of_run <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
			out_byte <= out_load_byte;
			is_digest <= out_load_dig;
			end_of_run <= out_load_eor;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// byte sequencer: salt bytes one per cycle, wait for compression on full blocks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= MODE_SEAL;
			pos_q <= '0;
			phase_q <= 1'b0;
			bits_q <= '0;
			k_q <= '0;
			pidx_q <= '0;
			c_q <= '0;
			last_q <= 1'b0;
			pad_pend_q <= 1'b0;
			req <= '0;
			init_hash <= 1'b0;
		end else begin
			// a write to the last block byte starts compression
			req.start <= blk_we && (blk_waddr == 6'd63);
			init_hash <= accept && (mode_q == MODE_SEAL) && !phase_q;
			if (mode_we) begin
				mode_q <= mode_wdata;
				pos_q <= '0;
				phase_q <= 1'b0;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (accept) begin
							c_q <= cipher_w;
							last_q <= is_last;
							pos_q <= is_last ? '0 : pos_next;
							if (mode_q == MODE_SEAL) begin
								if (!phase_q) begin
									bits_q <= '0;
									k_q <= '0;
									phase_q <= 1'b1;
									state_q <= S_INTRO;
								end else begin
									state_q <= S_DATA;
								end
							end
						end
					end
					S_INTRO: begin
						if (blk_we) begin
							bits_q <= bits_q + 64'd8;
							k_q <= 7'(k_q + 7'd1);
							if (k_q == 7'd63) state_q <= S_DATA;
						end
					end
					S_DATA: begin
						if (blk_we) begin
							bits_q <= bits_q + 64'd8;
							k_q <= '0;
							state_q <= last_q ? S_OUTRO : S_IDLE;
						end
					end
					S_OUTRO: begin
						if (blk_we) begin
							bits_q <= bits_q + 64'd8;
							k_q <= 7'(k_q + 7'd1);
							if (k_q == 7'd63) begin
								state_q <= S_PAD;
								pad_pend_q <= 1'b1;
								pidx_q <= 6'(bits_q[8:3] + 6'd1);
							end
						end
					end
					S_PAD: begin
						// marker byte, then zeros up to the length field
						if (blk_we) begin
							pad_pend_q <= 1'b0;
							pidx_q <= 6'(pidx_q + 6'd1);
							if (pidx_q == 6'd55) begin
								state_q <= S_LEN;
								k_q <= '0;
							end
						end
					end
					S_LEN: begin
						if (blk_we) begin
							k_q <= 7'(k_q + 7'd1);
							if (k_q == 7'd7) state_q <= S_FLUSH;
						end
					end
					S_FLUSH: begin
						if (!sts.busy) begin
							k_q <= '0;
							state_q <= S_DIG;
						end
					end
					S_DIG: begin
						if (out_free) begin
							k_q <= 7'(k_q + 7'd1);
							if (k_q == 7'(DigestBytes - 1)) begin
								state_q <= S_IDLE;
								phase_q <= 1'b0;
							end
						end
					end
				endcase
			end
		end
	end

`ifndef SYNTH
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte))
		else $error("result dropped while stalled");
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.busy |-> !in_ready)
		else $error("input taken during compression");
	a_dig_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_digest && end_of_run |-> state_q == S_IDLE)
		else $error("digest end out of order");
`endif

endmodule

FILE: hdl/xcs_compress.sv
module xcs_compress
	import xcs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  xcs_cmp_req_t req,
	output xcs_cmp_sts_t sts,
	// block byte memory write port, owned by the sequencer
	input  logic         blk_we,
	input  logic [5:0]   blk_waddr,
	input  logic [7:0]   blk_wdata,
	// hash word reload and read
	input  logic         init_hash,
	input  logic [2:0]   hash_raddr,
	output logic [31:0]  hash_rdata
);

	typedef enum logic [1:0] {
		C_IDLE, C_LOAD, C_ROUND, C_FOLD
	} cstate_t;

	cstate_t     state_q;
	logic [7:0]  blk_mem [64];
	logic [7:0]  blk_rd_q;
	logic [31:0] w_q [16];
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [6:0]  cnt_q;
	logic [31:0] a_w, e_w, t1_w, t2_w, wnew_w;

	function automatic logic [31:0] rr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// byte memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (blk_we)
			blk_mem[blk_waddr] <= blk_wdata;
		blk_rd_q <= blk_mem[cnt_q[5:0]];
	end

	// round logic over the sliding 16-word schedule window
	assign a_w = v_q[0];
	assign e_w = v_q[4];
	assign wnew_w = (rr(w_q[14], 17) ^ rr(w_q[14], 19) ^ (w_q[14] >> 10)) + w_q[9]
		+ (rr(w_q[1], 7) ^ rr(w_q[1], 18) ^ (w_q[1] >> 3)) + w_q[0];
	assign t1_w = v_q[7] + (rr(e_w, 6) ^ rr(e_w, 11) ^ rr(e_w, 25))
		+ ((e_w & v_q[5]) ^ (~e_w & v_q[6])) + ROUND_K[cnt_q[5:0]] + w_q[0];
	assign t2_w = (rr(a_w, 2) ^ rr(a_w, 13) ^ rr(a_w, 22))
		+ ((a_w & v_q[1]) ^ (a_w & v_q[2]) ^ (v_q[1] & v_q[2]));

	// sequence the block: 64 byte loads, 64 rounds, then fold into the hash words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= INIT_WORDS[i];
				v_q[i] <= '0;
			end
			for (int i = 0; i < 16; i++) w_q[i] <= '0;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					if (init_hash)
						for (int i = 0; i < 8; i++) h_q[i] <= INIT_WORDS[i];
					if (req.start) begin
						state_q <= C_LOAD;
						cnt_q <= '0;
					end
				end
				C_LOAD: begin
					// byte read is registered and arrives in the cycle after its address; shift bytes into the window
					if (cnt_q != 7'd0) begin
						for (int i = 0; i < 15; i++)
							w_q[i] <= {w_q[i][23:0], w_q[i + 1][31:24]};
						w_q[15] <= {w_q[15][23:0], blk_rd_q};
					end
					if (cnt_q == 7'd64) begin
						state_q <= C_ROUND;
						cnt_q <= '0;
						for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					end else begin
						cnt_q <= 7'(cnt_q + 7'd1);
					end
				end
				C_ROUND: begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
					w_q[15] <= wnew_w;
					v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1_w;
					v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
					v_q[0] <= t1_w + t2_w;
					if (cnt_q == 7'd63)
						state_q <= C_FOLD;
					cnt_q <= 7'(cnt_q + 7'd1);
				end
				C_FOLD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	assign sts.busy = (state_q != C_IDLE) || req.start;
	assign hash_rdata = h_q[hash_raddr];

endmodule

FILE: tb/xorpad_cipher_with_salted_sha256_test.sv
module xorpad_cipher_with_salted_sha256_test;
	import xcs_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       dig;
		logic       eor;
	} out_item_t;

	// Tracks cipher and salted hash state and holds the expected output items
	class digest_board;
		logic       mode_bit;
		int         pad_pos;
		bit  [31:0] hw [8];
		bit  [7:0]  blk [64];
		bit  [63:0] bit_cnt;
		bit         in_msg;
		out_item_t  pending_q [$];
		int         errors;

		function new();
			mode_bit = MODE_SEAL;
			pad_pos = 0;
			for (int i = 0; i < 8; i++) hw[i] = INIT_WORDS[i];
			bit_cnt = 0;
			in_msg = 0;
			errors = 0;
		endfunction

		function void set_mode(logic m);
			mode_bit = m;
			pad_pos = 0;
			in_msg = 0;
		endfunction

		function void enqueue(out_item_t it);
			pending_q.insert(pending_q.size(), it);
		endfunction

		function bit [31:0] rotr(bit [31:0] x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress();
			bit [31:0] w [16];
			bit [31:0] v [8];
			bit [31:0] t1, t2, a2, a15;
			for (int i = 0; i < 16; i++)
				w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
			v = hw;
			for (int i = 0; i < 64; i++) begin
				if (i >= 16) begin
					a2 = w[(i - 2) & 15];
					a15 = w[(i - 15) & 15];
					w[i & 15] = (rotr(a2, 17) ^ rotr(a2, 19) ^ (a2 >> 10)) + w[(i - 7) & 15]
						+ (rotr(a15, 7) ^ rotr(a15, 18) ^ (a15 >> 3)) + w[i & 15];
				end
				t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i & 15];
				t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++)
				hw[i] += v[i];
		endfunction

		function void absorb(bit [7:0] b);
			int idx;
			idx = int'(bit_cnt[8:3]);
			blk[idx] = b;
			bit_cnt += 8;
			if (idx == 63)
				compress();
		endfunction

		// Append 0x80, zero fill and the big-endian bit length
		function void finish_hash();
			int idx;
			idx = int'(bit_cnt[8:3]);
			blk[idx] = 8'h80;
			idx++;
			if (idx > 56) begin
				while (idx < 64) begin
					blk[idx] = 0;
					idx++;
				end
				compress();
				idx = 0;
			end
			while (idx < 56) begin
				blk[idx] = 0;
				idx++;
			end
			for (int i = 0; i < 8; i++)
				blk[56 + i] = bit_cnt[8*(7-i) +: 8];
			compress();
		endfunction

		function void note_input(logic [7:0] b, logic last);
			logic [7:0] c;
			out_item_t it;
			c = b ^ PAD_TABLE[7'(pad_pos)];
			pad_pos = (pad_pos + 1 >= PadLength) ? 0 : pad_pos + 1;
			it.data = c;
			it.dig = 0;
			it.eor = 1;
			if (mode_bit == MODE_OPEN) begin
				if (last)
					pad_pos = 0;
				enqueue(it);
				return;
			end
			if (!in_msg) begin
				for (int i = 0; i < 8; i++) hw[i] = INIT_WORDS[i];
				bit_cnt = 0;
				for (int k = 0; k < 64; k++)
					absorb(SALT_INTRO[k]);
				in_msg = 1;
			end
			absorb(c);
			if (!last) begin
				enqueue(it);
				return;
			end
			it.eor = 0;
			enqueue(it);
			for (int k = 0; k < 64; k++)
				absorb(SALT_OUTRO[k]);
			finish_hash();
			for (int k = 0; k < DigestBytes; k++) begin
				it.data = hw[k >> 2][8*(3 - (k & 3)) +: 8];
				it.dig = 1;
				it.eor = (k == DigestBytes - 1);
				enqueue(it);
			end
			pad_pos = 0;
			in_msg = 0;
		endfunction

		function void check_result(logic [7:0] data, logic dig, logic eor);
			out_item_t e;
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected item: byte %h digest %b end %b", data, dig, eor);
				return;
			end
			e = pending_q.pop_front();
			if (e.data !== data || e.dig !== dig || e.eor !== eor) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected byte %h digest %b end %b, got %h %b %b",
						e.data, e.dig, e.eor, data, dig, eor);
			end
		endfunction
	endclass

	logic       clk = 0;
	logic       arst_n = 0;
	logic       mode_we = 0;
	logic       mode_wdata = 0;
	logic       in_valid = 0;
	logic       in_ready;
	logic [7:0] in_byte = 0;
	logic       is_last = 0;
	logic       out_valid;
	logic       out_ready = 0;
	logic [7:0] out_byte;
	logic       is_digest;
	logic       end_of_run;

	digest_board board = new();
	bit no_idle = 0;
	int hold_len = 0;
	int items_sent = 0;

	xorpad_cipher_with_salted_sha256 DUT (
		.clk(clk), .arst_n(arst_n),
		.mode_we(mode_we), .mode_wdata(mode_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .is_last(is_last),
		.out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
		.is_digest(is_digest), .end_of_run(end_of_run)
	);

	always #10 clk = ~clk;

	// Offer one item and hold it until taken
	task send_byte(logic [7:0] b, logic last);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		in_byte <= b;
		is_last <= last;
		do @(posedge clk); while (!in_ready);
		board.note_input(b, last);
		items_sent++;
	endtask

	// Wait for all results, let the engine settle, then write mode
	task write_mode(logic m);
		in_valid <= 0;
		while (board.pending_q.size() > 0) @(posedge clk);
		repeat (1500) @(posedge clk);
		mode_we <= 1;
		mode_wdata <= m;
		@(posedge clk);
		mode_we <= 0;
		board.set_mode(m);
	endtask

	task send_message(int len, bit terminate);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)), terminate && (i == len - 1));
	endtask

	// Receiver: random stalls, plus one long hold-off when requested
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_len > 0) begin
				out_ready <= 0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else begin
				n = no_idle ? 0 : $urandom_range(0, 17);
				if (n > 0) begin
					out_ready <= 0;
					repeat (n) @(posedge clk);
				end
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
			board.check_result(out_byte, is_digest, end_of_run);
		end
	end

	initial begin
		#100000000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int len;
		bit hold_done;
		hold_done = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: shortest seal message, extreme bytes, open mode, abort
		send_byte(8'h00, 1);
		send_byte(8'hFF, 0);
		send_byte(8'h7F, 0);
		send_byte(8'h80, 1);
		send_message(60, 1);
		write_mode(MODE_OPEN);
		send_byte(8'h00, 0);
		send_byte(8'hFF, 1);
		send_byte(8'hA5, 0);
		send_byte(8'h5A, 0);
		write_mode(MODE_SEAL);
		send_byte(8'h3C, 0);
		send_byte(8'hC3, 0);
		write_mode(MODE_SEAL);
		send_byte(8'h11, 1);

		// Random phases of messages in either mode
		while (items_sent < 420) begin
			write_mode(1'($urandom_range(0, 1)));
			no_idle = ($urandom_range(0, 3) == 0);
			if (!hold_done && items_sent > 120) begin
				hold_len = 800;
				hold_done = 1;
			end
			repeat ($urandom_range(1, 4)) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 260)
					: $urandom_range(1, 70);
				if (len > 430 - items_sent)
					len = 430 - items_sent;
				if (len > 0)
					send_message(len, $urandom_range(0, 5) != 0);
			end
			no_idle = 0;
		end
		in_valid <= 0;

		while (board.pending_q.size() > 0) @(posedge clk);
		repeat (1500) @(posedge clk);
		if (board.errors == 0 && board.pending_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/xcs_pkg.sv
hdl/xcs_compress.sv
hdl/xorpad_cipher_with_salted_sha256.sv
tb/xorpad_cipher_with_salted_sha256_test.sv
